>>> hw/rtl/lck_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value store package
// Shared constants and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lck_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int CFG_AW = 3;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } lck_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } lck_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/lck_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value store channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lck_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink (input valid, input req_type, input key, input value, output ready);
endinterface

interface lck_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;
  logic               evicted;

  modport source (output valid, output hit, output read_value, output evicted, input ready);
  modport sink (input valid, input hit, input read_value, input evicted, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lck_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module lck_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                     wdata,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lck_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value store controller
// Sequences accept, scan of the key memory, compare drain and commit.
// ----------------------------------------------------------------------------
module lck_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lck_pkg::lck_stat_t stat,
  output lck_pkg::lck_cmd_t      cmd
);
  import lck_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (stat.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lck_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value store datapath
// Key and value memories, valid bits, recency ages, scan compare and result
// register.
// ----------------------------------------------------------------------------
module lck_datapath #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lck_pkg::lck_cmd_t  cmd,
  output lck_pkg::lck_stat_t      stat,
  input  wire logic [4:0]         capacity,
  input  wire logic               req_type,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] value,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic signed [31:0]      out_read_value,
  output logic                    out_evicted
);
  import lck_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic              req_put;
  logic [DATA_W-1:0] req_key;
  logic [DATA_W-1:0] req_value;

  logic [IDX_W-1:0]  idx;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;

  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [IDX_W-1:0]  found_age;
  logic [DATA_W-1:0] found_val;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic              any_valid;
  logic [IDX_W-1:0]  best_idx;
  logic [IDX_W-1:0]  best_age;

  logic [CAPACITY-1:0] valid;
  logic [IDX_W-1:0]    age [CAPACITY];
  logic [CNT_W-1:0]    fill;

  logic [DATA_W-1:0] key_rd;
  logic [DATA_W-1:0] val_rd;

  logic [CW-1:0]     cap_w;
  logic [CW-1:0]     eff_cap;
  logic              use_free;
  logic              evict;
  logic [IDX_W-1:0]  ins_slot;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  ram_addr;
  logic              key_we;
  logic              val_we;
  logic              e_valid;
  logic [IDX_W-1:0]  e_age;

  assign cap_w = CW'(capacity);

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (cap_w > CW'(CAPACITY)) begin
      eff_cap = CW'(CAPACITY);
    end else begin
      eff_cap = cap_w;
    end
  end

  assign use_free = (CW'(fill) < eff_cap) && free_found;
  assign evict    = req_put && !found && !use_free && any_valid;
  assign ins_slot = use_free ? free_idx : best_idx;
  assign slot     = found ? found_idx : ins_slot;
  assign ram_addr = cmd.commit ? slot : idx;
  assign key_we   = cmd.commit && req_put && !found;
  assign val_we   = cmd.commit && req_put;

  assign e_valid = valid[cmp_idx];
  assign e_age   = age[cmp_idx];

  assign stat.last     = (idx == LAST_IDX);
  assign stat.out_free = !out_valid || out_ready;

  lck_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .addr  (ram_addr),
    .wdata (req_key),
    .rdata (key_rd)
  );

  lck_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .addr  (ram_addr),
    .wdata (req_value),
    .rdata (val_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_put   <= (req_type == REQ_PUT);
      req_key   <= key;
      req_value <= value;
      idx       <= '0;
    end else if (cmd.rd_en && !stat.last) begin
      idx <= idx + 1'b1;
    end
    cmp_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid  <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      any_valid  <= 1'b0;
    end else begin
      cmp_valid <= cmd.rd_en;
      if (cmd.load) begin
        found      <= 1'b0;
        free_found <= 1'b0;
        any_valid  <= 1'b0;
      end else if (cmp_valid) begin
        if (e_valid && key_rd == req_key) begin
          found <= 1'b1;
        end
        if (!e_valid) begin
          free_found <= 1'b1;
        end
        if (e_valid) begin
          any_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_valid && !cmd.load) begin
      if (e_valid && key_rd == req_key && !found) begin
        found_idx <= cmp_idx;
        found_age <= e_age;
        found_val <= val_rd;
      end
      if (!e_valid && !free_found) begin
        free_idx <= cmp_idx;
      end
      if (e_valid && (!any_valid || e_age > best_age)) begin
        best_idx <= cmp_idx;
        best_age <= e_age;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill  <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        age[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (found) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (IDX_W'(i) == found_idx) begin
            age[i] <= '0;
          end else if (valid[i] && age[i] < found_age) begin
            age[i] <= age[i] + 1'b1;
          end
        end
      end else if (req_put) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (IDX_W'(i) == ins_slot) begin
            age[i]   <= '0;
            valid[i] <= 1'b1;
          end else if (valid[i]) begin
            age[i] <= age[i] + 1'b1;
          end
        end
        if (!evict) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit     <= found;
      out_evicted <= evict;
      if (req_put) begin
        out_read_value <= '0;
      end else if (found) begin
        out_read_value <= found_val;
      end else begin
        out_read_value <= MISS_VALUE;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lru_cache_key_value.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value store
// Fully associative store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request passes through accept, a scan that reads the key and value
// memories one entry at a time through their single port, the last compare
// and the commit before the next one can be accepted; the commit waits until
// the output register is free. A finished result waits in the output
// register, so the next request is taken while it is still pending. Valid
// bits and ages sit in flip-flops cleared at reset; no clearing pass is run.
// ----------------------------------------------------------------------------
module lru_cache_key_value #(
  parameter int CAPACITY = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  lck_req_if.sink                           req,
  lck_rsp_if.source                         rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lck_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);
  import lck_pkg::*;

  logic [CAP_W-1:0] capacity;
  lck_cmd_t         cmd;
  lck_stat_t        stat;
  logic             in_ready;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign req.ready = in_ready;

  lck_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lck_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .capacity       (capacity),
    .req_type       (req.req_type),
    .key            (req.key),
    .value          (req.value),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_hit        (rsp.hit),
    .out_read_value (rsp.read_value),
    .out_evicted    (rsp.evicted)
  );

  a_beat_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.commit))
    else $error("Response beat raised without a commit.");

  a_scan_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (cmd.rd_en && !req.ready))
    else $error("Scan did not start after an accepted beat.");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en || cmd.commit) |-> !req.ready)
    else $error("Request accepted while a request is in progress.");

  a_commit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp.valid || rsp.ready))
    else $error("Commit would overwrite a pending response beat.");

endmodule
`default_nettype wire
